### hdl/ptt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and codes for the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int unsigned KEY_W    = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_START  = 2'd1,
    FN_STOP   = 2'd2,
    FN_TICK   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_DUP   = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_MISS  = 3'd3,
    STAT_FIRED = 3'd4,
    STAT_IDLE  = 3'd5
  } status_t;

endpackage
`default_nettype wire

### hdl/periodic_timer_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timers keyed by id, held in one synchronous memory.
// ----------------------------------------------------------------------------
// Each request is handled by a walk over the occupied slots of the table
// memory, one slot per cycle through its single read port unless a tick
// must hold a fired entry while the output register is full. The memory
// read is registered, so the read address is steered from the next index.
// Insert, start and stop end the walk early when the id is found. A new
// request is taken once the previous one has placed its final result in the
// output register. Slots fill in insertion order and are never freed, so
// occupancy is a fill count and the memory needs no clearing after reset.
// Requests: tuser carries the operation, tdata the id and period. Results:
// tuser the status, tdata the fired id, tlast marks a request's last result.
// ----------------------------------------------------------------------------
module periodic_timer_table #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [23:0]                in_tdata,   // [7:0] timer_id, [23:8] period
  input  wire ptt_pkg::func_t             in_tuser,   // [1:0] func
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] fired_id
  output ptt_pkg::status_t                out_tuser,  // [2:0] status
  output logic                            out_tlast
);
  import ptt_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned UW = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic                   enabled;
    logic [COUNT_WIDTH-1:0] count;
    logic [COUNT_WIDTH-1:0] period;
  } entry_t;

  typedef enum logic [2:0] {
    SM_IDLE = 3'b001,
    SM_SCAN = 3'b010,
    SM_TICK = 3'b100
  } state_t;

  // table memory
  entry_t mem [ENTRIES];
  entry_t mem_q;
  logic   [IW-1:0] rd_addr;
  logic            we;
  logic   [IW-1:0] waddr;
  entry_t          wdata;

  state_t state_r, state_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] idx_r, idx_nxt;
  func_t                  func_r;
  logic [KEY_W-1:0]       id_r;
  logic [COUNT_WIDTH-1:0] period_r;

  // fired entry held back until we know whether it is the last one
  logic             pend_v_r, pend_v_nxt;
  logic [KEY_W-1:0] pend_id_r, pend_id_nxt;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [KEY_W-1:0] out_id_r;
  logic             out_last_r;

  logic             out_free;
  logic             emit;
  status_t          emit_status;
  logic [KEY_W-1:0] emit_id;
  logic             emit_last;
  logic             adv;
  logic             walk_end;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic             fire;
  logic             accept;

  assign in_tready = (state_r == SM_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign walk_end  = (idx_r >= used_r);
  assign cnt_inc   = mem_q.count + 1'b1;
  assign fire      = mem_q.enabled && (cnt_inc >= mem_q.period);

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    idx_nxt     = idx_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    adv         = 1'b0;
    we          = 1'b0;
    waddr       = idx_r[IW-1:0];
    wdata       = mem_q;
    emit        = 1'b0;
    emit_status = STAT_OK;
    emit_id     = '0;
    emit_last   = 1'b1;

    unique case (state_r)
      SM_IDLE: begin
        idx_nxt    = '0;
        pend_v_nxt = 1'b0;
        if (accept) begin
          state_nxt = (in_tuser == FN_TICK) ? SM_TICK : SM_SCAN;
        end
      end

      SM_SCAN: begin
        if (walk_end) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = SM_IDLE;
            if (func_r != FN_INSERT) begin
              emit_status = STAT_MISS;
            end else if (used_r >= UW'(ENTRIES)) begin
              emit_status = STAT_FULL;
            end else begin
              emit_status   = STAT_OK;
              we            = 1'b1;
              waddr         = used_r[IW-1:0];
              wdata.key     = id_r;
              wdata.enabled = 1'b0;
              wdata.count   = '0;
              wdata.period  = '0;
              used_nxt      = used_r + 1'b1;
            end
          end
        end else if (mem_q.key == id_r) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = SM_IDLE;
            if (func_r == FN_INSERT) begin
              emit_status = STAT_DUP;
            end else begin
              emit_status = STAT_OK;
              we          = 1'b1;
              wdata.count = '0;
              if (func_r == FN_START) begin
                wdata.enabled = 1'b1;
                wdata.period  = period_r;
              end else begin
                wdata.enabled = 1'b0;
              end
            end
          end
        end else begin
          adv = 1'b1;
        end
      end

      SM_TICK: begin
        if (walk_end) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = pend_v_r ? STAT_FIRED : STAT_IDLE;
            emit_id     = pend_v_r ? pend_id_r : '0;
            state_nxt   = SM_IDLE;
          end
        end else if (!mem_q.enabled) begin
          adv = 1'b1;
        end else if (!(fire && pend_v_r && !out_free)) begin
          adv         = 1'b1;
          we          = 1'b1;
          wdata.count = fire ? '0 : cnt_inc;
          if (fire) begin
            if (pend_v_r) begin
              emit        = 1'b1;
              emit_status = STAT_FIRED;
              emit_id     = pend_id_r;
              emit_last   = 1'b0;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = mem_q.key;
          end
        end
      end

      default: state_nxt = SM_IDLE;
    endcase

    if (adv) begin
      idx_nxt = idx_r + 1'b1;
    end
    rd_addr = idx_nxt[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SM_IDLE;
      used_r      <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      idx_r    <= idx_nxt;
      pend_v_r <= pend_v_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
    if (accept) begin
      func_r   <= in_tuser;
      id_r     <= in_tdata[KEY_W-1:0];
      period_r <= COUNT_WIDTH'(in_tdata[KEY_W +: PERIOD_W]);
    end
    if (emit) begin
      out_status_r <= emit_status;
      out_id_r     <= emit_id;
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
